// File: hdl/wli_pkg.sv
`timescale 1ns / 1ps

package wli_pkg;

  // Item kinds carried by the mode field.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  // Configuration register indexes.
  localparam logic [0:0] CFG_CALIB_COLUMN = 1'b0;
  localparam logic [0:0] CFG_POINT_COUNT  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_LINE = 3'd1;
  localparam logic [2:0] ST_ABOVE   = 3'd2;
  localparam logic [2:0] ST_BEYOND  = 3'd3;
  localparam logic [2:0] ST_ZERO_B  = 3'd4;

  // Divider step counts for the row and for the interpolation quotient.
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_ROW    = 6'd32;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_INTERP = 6'd33;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [31:0]          rem_init;
    logic [32:0]          low_bits;
    logic [31:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quo;
  } div_rsp_t;

endpackage

// File: hdl/wli_div.sv
`timescale 1ns / 1ps

module wli_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wli_pkg::div_req_t  req_i,
  output wli_pkg::div_rsp_t  rsp_o
);
  import wli_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]          rem_q, rem_d;
  logic [32:0]          dq_q, dq_d;
  logic [31:0]          dvs_q, dvs_d;
  logic [32:0]          trial_w;
  logic [32:0]          sub_w;
  logic                 ge_w;

  // One restoring step: bring in the next dividend bit and try the subtract.
  // The caller guarantees that the initial remainder is below the divisor.
  assign trial_w = {rem_q, dq_q[32]};
  assign sub_w   = trial_w - {1'b0, dvs_q};
  assign ge_w    = trial_w >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      dq_d   = req_i.low_bits;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        rem_d = ge_w ? sub_w[31:0] : trial_w[31:0];
        dq_d  = {dq_q[31:0], ge_w};
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.quo  = dq_q;

endmodule

// File: hdl/waterline_level_interpolator_top.sv
`timescale 1ns / 1ps
// Load beats produce no result and leave the block ready, so the next beat is taken right after.
// A measure beat gives its result after a walk of the table up to the entry that holds the row
// and a 32-step and a 33-step pass of the shared divider. Status-only results come sooner.
// No new beat is taken until the result of a measure beat is in the output register, and that
// register waits for out_ready_i while it still holds an earlier result.
// Reset (asynchronous, active low) clears the sequencer, the output valid, calib_column
// to 0 and point_count to 1; the calibration table is not cleared.
module waterline_level_interpolator_top #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] entry_level_i,
  input  logic [31:0] entry_span_i,
  input  logic [31:0] coef_a_i,
  input  logic [31:0] coef_b_i,
  input  logic [31:0] coef_c_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] water_level_o,
  output logic [2:0]  status_o
);
  import wli_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_DIVSET = 4'd2;
  localparam logic [3:0] S_DIV1W  = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_RDP    = 4'd6;
  localparam logic [3:0] S_DIFF   = 4'd7;
  localparam logic [3:0] S_MUL2   = 4'd8;
  localparam logic [3:0] S_DIV2S  = 4'd9;
  localparam logic [3:0] S_DIV2W  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [11:0]        calib_column_q, calib_column_d;
  logic [4:0]         point_count_q, point_count_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        water_level_q, water_level_d;
  logic [2:0]         status_q, status_d;

  logic signed [31:0] a_q, a_d;
  logic signed [31:0] b_q, b_d;
  logic signed [31:0] c_q, c_d;
  logic signed [45:0] num_q, num_d;
  logic               neg_q, neg_d;
  logic [31:0]        rem_q, rem_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [31:0]        li_q, li_d;
  logic [31:0]        s_q, s_d;
  logic [31:0]        frac_q, frac_d;
  logic [32:0]        mag_q, mag_d;
  logic               dneg_q, dneg_d;
  logic [64:0]        prod_q, prod_d;
  logic [31:0]        lvl_q, lvl_d;
  logic [2:0]         st_q, st_d;

  logic [63:0]        entry_mem [MAX_POINTS];
  logic [63:0]        rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_fire;
  logic signed [44:0] ax_w;
  logic signed [45:0] num_w;
  logic [45:0]        num_neg_w;
  logic [44:0]        nmag_w;
  logic [31:0]        bmag_w;
  logic               row_ovf_w;
  logic [31:0]        q_w;
  logic [31:0]        span_w;
  logic [31:0]        lvl_rd_w;
  logic               rem_ge_w;
  logic [NW-1:0]      n_w;
  logic               last_w;
  logic [32:0]        diff_w;
  logic [32:0]        diff_neg_w;
  logic [64:0]        mul_w;
  logic [31:0]        interp_w;
  logic               out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign mem_we = in_fire && (mode_i == MODE_LOAD) && (32'(entry_index_i) < MAX_POINTS);
  assign mem_wa = AW'(entry_index_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= {entry_level_i, entry_span_i};
    end
    rd_q <= entry_mem[idx_q];
  end

  wli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Row numerator -(a*x0 + c), later scaled by 2^16 before the divide.
  assign ax_w      = a_q * $signed({1'b0, calib_column_q});
  assign num_w     = -($signed({ax_w[44], ax_w}) + $signed({{14{c_q[31]}}, c_q}));
  assign num_neg_w = -num_q;
  assign nmag_w    = num_q[45] ? num_neg_w[44:0] : num_q[44:0];
  assign bmag_w    = b_q[31] ? (~b_q + 32'd1) : b_q;
  // A quotient that needs more than 32 bits always overflows the row.
  assign row_ovf_w = {3'b000, nmag_w[44:16]} >= bmag_w;
  assign q_w       = div_rsp.quo[31:0];

  assign span_w   = rd_q[31:0];
  assign lvl_rd_w = rd_q[63:32];
  assign rem_ge_w = rem_q >= span_w;

  always_comb begin
    if (point_count_q == '0) begin
      n_w = NW'(1);
    end else if (32'(point_count_q) > MAX_POINTS) begin
      n_w = NW'(MAX_POINTS);
    end else begin
      n_w = NW'(point_count_q);
    end
  end

  assign last_w     = (NW'(idx_q) + NW'(1)) == n_w;
  assign diff_w     = {lvl_rd_w[31], lvl_rd_w} - {li_q[31], li_q};
  assign diff_neg_w = -diff_w;
  assign mul_w      = mag_q * frac_q;
  assign interp_w   = dneg_q ? (li_q - q_w) : (li_q + q_w);

  always_comb begin
    calib_column_d = calib_column_q;
    point_count_d  = point_count_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CALIB_COLUMN: calib_column_d = cfg_data_i;
        CFG_POINT_COUNT:  point_count_d  = cfg_data_i[4:0];
        default:          calib_column_d = calib_column_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    num_d   = num_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    li_d    = li_q;
    s_d     = s_q;
    frac_d  = frac_q;
    mag_d   = mag_q;
    dneg_d  = dneg_q;
    prod_d  = prod_q;
    lvl_d   = lvl_q;
    st_d    = st_q;
    div_req = '0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (mode_i == MODE_MEASURE)) begin
          a_d     = coef_a_i;
          b_d     = coef_b_i;
          c_d     = coef_c_i;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        lvl_d = '0;
        if ((a_q == '0) && (b_q == '0) && (c_q == '0)) begin
          st_d    = ST_NO_LINE;
          state_d = S_OUT;
        end else if (b_q == '0) begin
          st_d    = ST_ZERO_B;
          state_d = S_OUT;
        end else begin
          num_d   = num_w;
          state_d = S_DIVSET;
        end
      end
      S_DIVSET: begin
        neg_d = num_q[45] ^ b_q[31];
        if (row_ovf_w) begin
          st_d    = ST_BEYOND;
          state_d = S_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = DIV_STEPS_ROW;
          div_req.rem_init = {3'b000, nmag_w[44:16]};
          div_req.low_bits = {nmag_w[15:0], 16'h0000, 1'b0};
          div_req.divisor  = bmag_w;
          state_d          = S_DIV1W;
        end
      end
      S_DIV1W: begin
        if (div_rsp.done) begin
          rem_d = q_w;
          idx_d = '0;
          if (neg_q) begin
            if (q_w > 32'h8000_0000) begin
              st_d    = ST_BEYOND;
              state_d = S_OUT;
            end else if (q_w != '0) begin
              // Any negative row lies above the first span.
              st_d    = ST_ABOVE;
              state_d = S_OUT;
            end else begin
              state_d = S_RD;
            end
          end else if (q_w[31]) begin
            st_d    = ST_BEYOND;
            state_d = S_OUT;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rem_ge_w) begin
          rem_d = rem_q - span_w;
          if (last_w) begin
            st_d    = ST_BEYOND;
            state_d = S_OUT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end else if (idx_q == '0) begin
          st_d    = ST_ABOVE;
          state_d = S_OUT;
        end else begin
          li_d    = lvl_rd_w;
          s_d     = span_w;
          frac_d  = span_w - rem_q;
          idx_d   = idx_q - 1'b1;
          state_d = S_RDP;
        end
      end
      S_RDP: begin
        state_d = S_DIFF;
      end
      S_DIFF: begin
        dneg_d  = diff_w[32];
        mag_d   = diff_w[32] ? diff_neg_w : diff_w;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod_d  = mul_w;
        state_d = S_DIV2S;
      end
      S_DIV2S: begin
        // The product is at most mag*span, so its top 32 bits stay below the span.
        div_req.start    = 1'b1;
        div_req.steps    = DIV_STEPS_INTERP;
        div_req.rem_init = prod_q[64:33];
        div_req.low_bits = prod_q[32:0];
        div_req.divisor  = s_q;
        state_d          = S_DIV2W;
      end
      S_DIV2W: begin
        if (div_rsp.done) begin
          lvl_d   = interp_w;
          st_d    = ST_OK;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (st_d != ST_OK) begin
      lvl_d = '0;
    end
  end

  assign out_valid_d   = (out_valid_q && !out_ready_i) || out_load;
  assign water_level_d = out_load ? lvl_q : water_level_q;
  assign status_d      = out_load ? st_q : status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      calib_column_q <= '0;
      point_count_q  <= 5'd1;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      calib_column_q <= calib_column_d;
      point_count_q  <= point_count_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q           <= a_d;
    b_q           <= b_d;
    c_q           <= c_d;
    num_q         <= num_d;
    neg_q         <= neg_d;
    rem_q         <= rem_d;
    idx_q         <= idx_d;
    li_q          <= li_d;
    s_q           <= s_d;
    frac_q        <= frac_d;
    mag_q         <= mag_d;
    dneg_q        <= dneg_d;
    prod_q        <= prod_d;
    lvl_q         <= lvl_d;
    st_q          <= st_d;
    water_level_q <= water_level_d;
    status_q      <= status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign water_level_o = water_level_q;
  assign status_o      = status_q;

`ifndef SYNTH
  a_level_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (water_level_o == '0))
    else $error("nonzero level with a failing status");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == S_DIV1W) || (state_q == S_DIV2W)))
    else $error("divider finished outside a wait state");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && out_valid_q && !out_ready_i) |=> (state_q == S_OUT))
    else $error("result dropped while the output register was full");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input taken while a measurement is in progress");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import wli_pkg::*;

  localparam int          TBL_DEPTH     = 16;
  localparam int          SETTLE_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic        mode;
    logic [3:0]  idx;
    logic [31:0] lvl;
    logic [31:0] span;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } wl_item_t;

  typedef struct {
    logic [31:0] level;
    logic [2:0]  status;
  } reading_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_index_i   = CFG_CALIB_COLUMN;
  logic [11:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        mode_i        = MODE_LOAD;
  logic [3:0]  entry_index_i = '0;
  logic [31:0] entry_level_i = '0;
  logic [31:0] entry_span_i  = '0;
  logic [31:0] coef_a_i      = '0;
  logic [31:0] coef_b_i      = '0;
  logic [31:0] coef_c_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [31:0] water_level_o;
  logic [2:0]  status_o;

  // Shadow of the block's state, updated when a beat or a register write lands.
  logic [31:0] lvl_tbl [TBL_DEPTH];
  logic [31:0] span_tbl[TBL_DEPTH];
  logic [11:0] calib_col = '0;
  logic [4:0]  point_cnt = 5'd1;

  reading_t    pending_readings[$];
  int          error_count     = 0;
  int unsigned cycle_count     = 0;
  int          sink_hold_left  = 0;
  bit          src_idle_en     = 1'b1;
  bit          snk_idle_en     = 1'b1;

  waterline_level_interpolator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .entry_index_i (entry_index_i),
    .entry_level_i (entry_level_i),
    .entry_span_i  (entry_span_i),
    .coef_a_i      (coef_a_i),
    .coef_b_i      (coef_b_i),
    .coef_c_i      (coef_c_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .water_level_o (water_level_o),
    .status_o      (status_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int active_entries();
    int n;
    n = int'(point_cnt);
    if (n < 1) n = 1;
    if (n > TBL_DEPTH) n = TBL_DEPTH;
    return n;
  endfunction

  function automatic reading_t predict_reading(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c);
    reading_t        r;
    longint          sa, sb, sc, x0, num, row, s0, li, lp, diff, lvl;
    longint unsigned rem, s, mag, frac, t;
    int              n;
    r.level = '0;
    r.status = ST_BEYOND;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    sc = longint'($signed(c));
    x0 = {52'd0, calib_col};
    if (sa == 0 && sb == 0 && sc == 0) begin
      r.status = ST_NO_LINE;
    end else if (sb == 0) begin
      r.status = ST_ZERO_B;
    end else begin
      num = -(sa * x0 + sc);
      row = (num * 65536) / sb;
      s0 = {32'd0, span_tbl[0]};
      if (row > 64'sh7FFF_FFFF || row < -64'sh8000_0000) begin
        r.status = ST_BEYOND;
      end else if (row < s0) begin
        r.status = ST_ABOVE;
      end else begin
        n = active_entries();
        rem = row;
        for (int i = 0; i < n; i++) begin
          s = {32'd0, span_tbl[i]};
          if (rem >= s) begin
            rem -= s;
          end else begin
            // Reached only for i >= 1, since the row is at least the first span.
            li = longint'($signed(lvl_tbl[i]));
            lp = longint'($signed(lvl_tbl[i-1]));
            diff = lp - li;
            mag = (diff < 0) ? -diff : diff;
            frac = s - rem;
            t = (mag * frac) / s;
            lvl = (diff < 0) ? li - longint'(t) : li + longint'(t);
            r.level = lvl[31:0];
            r.status = ST_OK;
            break;
          end
        end
      end
    end
    return r;
  endfunction

  // Receiver: random stalls plus an optional long hold-off counted here.
  always @(posedge clk_i) begin
    if (sink_hold_left != 0) begin
      out_ready_i <= 1'b0;
      sink_hold_left <= sink_hold_left - 1;
    end else if (snk_idle_en && $urandom_range(0, 99) < 7) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readings.size() == 0) begin
        flag_error($sformatf("result with nothing pending: level %h status %0d",
                             water_level_o, status_o));
      end else begin
        want = pending_readings.pop_front();
        if (water_level_o !== want.level)
          flag_error($sformatf("water_level %h, expected %h", water_level_o, want.level));
        if (status_o !== want.status)
          flag_error($sformatf("status %0d, expected %0d", status_o, want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** waterline_level_interpolator_top: FAILED **");
      $finish;
    end
  end

  // Drives one beat and waits for it to be taken; the shadow state follows at that edge.
  task automatic send_item(input wl_item_t it);
    if (src_idle_en && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 25);
    end
    mode_i        <= it.mode;
    entry_index_i <= it.idx;
    entry_level_i <= it.lvl;
    entry_span_i  <= it.span;
    coef_a_i      <= it.a;
    coef_b_i      <= it.b;
    coef_c_i      <= it.c;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.mode == MODE_LOAD) begin
      lvl_tbl[it.idx]  = it.lvl;
      span_tbl[it.idx] = it.span;
    end else begin
      pending_readings.push_back(predict_reading(it.a, it.b, it.c));
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [11:0] col, input logic [4:0] cnt);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_CALIB_COLUMN;
    cfg_data_i  <= col;
    @(posedge clk_i);
    calib_col = col;
    cfg_index_i <= CFG_POINT_COUNT;
    cfg_data_i  <= {7'd0, cnt};
    @(posedge clk_i);
    point_cnt = cnt;
    cfg_we_i <= 1'b0;
  endtask

  function automatic wl_item_t random_fields();
    wl_item_t it;
    it.mode = MODE_MEASURE;
    it.idx  = 4'($urandom);
    it.lvl  = $urandom;
    it.span = $urandom;
    it.a    = $urandom;
    it.b    = $urandom;
    it.c    = $urandom;
    return it;
  endfunction

  task automatic load_entry(input logic [3:0] idx, input logic [31:0] lvl,
                            input logic [31:0] span);
    wl_item_t it;
    it = random_fields();
    it.mode = MODE_LOAD;
    it.idx  = idx;
    it.lvl  = lvl;
    it.span = span;
    send_item(it);
  endtask

  task automatic measure_line(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c);
    wl_item_t it;
    it = random_fields();
    it.a = a;
    it.b = b;
    it.c = c;
    send_item(it);
  endtask

  function automatic logic [31:0] sane_span();
    if ($urandom_range(0, 9) == 0) return '0;
    return $urandom_range(1 << 14, 1 << 22);
  endfunction

  // Spans of 0.25 to 64 pixels each in 16.16, a tenth of them zero; levels mostly falling with depth.
  task automatic load_fresh_table();
    logic [31:0] lvl;
    bit          scattered;
    lvl = $urandom;
    scattered = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      load_entry(4'(i), scattered ? $urandom : lvl, sane_span());
      lvl = lvl - $urandom_range(0, 1 << 24);
    end
  endtask

  // Chooses a row that lands inside an entry, on a boundary, past the end or above.
  function automatic longint pick_row();
    int              n, k, sel;
    longint unsigned base, total;
    longint          row;
    n = active_entries();
    k = $urandom_range(0, n - 1);
    sel = $urandom_range(0, 99);
    base = 0;
    total = 0;
    for (int i = 0; i < n; i++) begin
      if (i < k) base += {32'd0, span_tbl[i]};
      total += {32'd0, span_tbl[i]};
    end
    if (sel < 65)
      row = longint'(base) + ((span_tbl[k] == 0) ? 0 : ($urandom % span_tbl[k]));
    else if (sel < 80)
      row = base;
    else if (sel < 88)
      row = longint'(base) + ((span_tbl[k] == 0) ? 0 : span_tbl[k] - 1);
    else if (sel < 95)
      row = longint'(total) + $urandom_range(0, 1 << 20);
    else
      row = -longint'($urandom_range(1, 1 << 22));
    return row;
  endfunction

  function automatic wl_item_t line_at_row(input longint row);
    wl_item_t it;
    longint   a, b, c, x0;
    it = random_fields();
    x0 = {52'd0, calib_col};
    b = ($urandom_range(0, 3) == 0) ? 65536 : longint'($urandom_range(256, 1 << 20));
    if ($urandom_range(0, 1)) b = -b;
    a = longint'($urandom_range(0, 4096)) - 2048;
    c = -(a * x0 + (row * b) / 65536);
    it.a = a[31:0];
    it.b = b[31:0];
    it.c = c[31:0];
    return it;
  endfunction

  function automatic wl_item_t odd_measure();
    wl_item_t it;
    int       sel;
    it = random_fields();
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      it.a = '0;
      it.b = '0;
      it.c = '0;
    end else if (sel < 35) begin
      it.b = '0;
    end else if (sel < 55) begin
      // A nearly flat b pushes the row out of 32 bits.
      it.a = $urandom_range(0, 3);
      it.b = $urandom_range(1, 255);
      if ($urandom_range(0, 1)) it.b = -it.b;
    end
    return it;
  endfunction

  task automatic mixed_item(input int load_pct);
    int       sel;
    wl_item_t it;
    sel = $urandom_range(0, 99);
    if (sel < load_pct) begin
      load_entry(4'($urandom), $urandom,
                 ($urandom_range(0, 4) == 0) ? $urandom : sane_span());
    end else begin
      if (sel < 82) it = line_at_row(pick_row());
      else it = odd_measure();
      send_item(it);
    end
  endtask

  task automatic test_directed();
    // Reset configuration: column 0 and a single entry.
    load_entry(4'd0, 32'h7FFF_FFFF, 32'd10 << 16);
    load_entry(4'd1, 32'h8000_0000, 32'd20 << 16);
    load_entry(4'd2, 32'h0000_0000, 32'h0000_0000);
    load_entry(4'd3, 32'd100 << 16, 32'hFFFF_FFFF);
    measure_line(32'd0, 32'd65536, -(32'd5 << 16));
    measure_line(32'd0, 32'd65536, -(32'd15 << 16));
    drain_results();
    set_config(12'd100, 5'd4);
    measure_line(32'd0, 32'd0, 32'd0);
    measure_line(32'd1, 32'd0, 32'd5);
    measure_line(32'd0, 32'd1, 32'h8000_0001);
    measure_line(32'd0, 32'hFFFF_FFFF, 32'h8000_0001);
    measure_line(32'd0, 32'd65536, 32'd5 << 16);
    measure_line(32'd0, 32'd65536, -(32'd10 << 16));
    measure_line(32'd0, 32'd65536, -(32'd25 << 16));
    // Crosses the zero-span entry into the last one.
    measure_line(32'd0, 32'd65536, -(32'd30 << 16));
    measure_line(-32'd65536, 32'd65536, 32'd0);
    measure_line(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    measure_line(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain_results();
    set_config(12'd4095, 5'd3);
    measure_line(32'd0, 32'd65536, -(32'd40 << 16));
    measure_line(32'd256, 32'd65536, -(32'd1048320 + (32'd25 << 16)));
  endtask

  task automatic test_config_sweep();
    logic [11:0] cols[7];
    logic [4:0]  cnts[7];
    cols = '{12'd0, 12'd4095, 12'd2048, 12'd1, 12'd4095, 12'd0, 12'd0};
    cnts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd16, 5'd1};
    cols[6] = 12'($urandom);
    cnts[6] = 5'($urandom_range(1, 16));
    for (int p = 0; p < 7; p++) begin
      drain_results();
      set_config(cols[p], cnts[p]);
      load_fresh_table();
      repeat (40) mixed_item(0);
    end
  endtask

  task automatic test_random_mix();
    drain_results();
    set_config(12'($urandom), 5'd16);
    load_fresh_table();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    for (int k = 0; k < 650; k++) begin
      if (k == 300) begin
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
      end
      mixed_item(12);
    end
  endtask

  task automatic test_backpressure();
    sink_hold_left <= 3000;
    repeat (40) mixed_item(10);
  endtask

  task automatic test_paced_bursts();
    repeat (5) begin
      repeat (8) mixed_item(10);
      drain_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_random_mix();
    test_backpressure();
    test_paced_bursts();
    drain_results();
    if (pending_readings.size() != 0) flag_error("results still pending at the end");
    if (error_count == 0) begin
      $display("** waterline_level_interpolator_top: PASSED **");
    end else begin
      $display("** waterline_level_interpolator_top: FAILED **");
    end
    $finish;
  end

endmodule
